@@ rtl/rolz_pkg.sv @@
// Shared types, constants and helpers for the ROLZ decompressor core.
// No dependencies; used by rolz_decompressor_core and its testbench.
package rolz_pkg;

  localparam int unsigned HISTORY_SIZE      = 65536;
  localparam int unsigned SLOTS_PER_CONTEXT = 128;
  localparam int unsigned OUT_LANES         = 8;
  localparam int unsigned CONTEXTS          = 4096;
  localparam int unsigned MIN_MATCH         = 3;

  localparam int unsigned HIST_AW  = $clog2(HISTORY_SIZE);
  localparam int unsigned KEY_W    = $clog2(CONTEXTS);
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned CTX_AW   = KEY_W + SLOT_W;
  localparam int unsigned CTX_DEPTH = CONTEXTS << SLOT_W;
  localparam int unsigned FILL_W   = $clog2(OUT_LANES + 1);
  localparam int unsigned LEN_W    = 9;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SLOT  = 2'd1;
  localparam logic [1:0] ERR_INDEX = 2'd2;
  localparam logic [1:0] ERR_EARLY = 2'd3;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_LITERAL,
    PH_LENGTH
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MLOOK,
    ST_MCHK,
    ST_RD,
    ST_WR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_stream;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_run;
    logic [1:0]  error_code;
  } out_item_t;

  // per-context row state: wrapped flag and next round-robin slot
  typedef struct packed {
    logic              wrapped;
    logic [SLOT_W-1:0] next;
  } meta_t;

  function automatic logic [KEY_W-1:0] ctx_key(input logic [7:0] older,
                                               input logic [7:0] newer);
    logic [11:0] h;
    h = {older, 4'b0000} ^ {4'b0000, newer};
    return KEY_W'(h);
  endfunction

endpackage

@@ rtl/rolz_decompressor_core.sv @@
// ROLZ decompressor top level: parser, match sequencer and output packer.
// Depends on rolz_pkg and rolz_ram (history, context slots, row state).
//
//  channel | ports                          | carries
//  in      | in_valid, in_ready, in_data    | one compressed byte + new_stream
//  out     | out_valid, out_ready, out_data | up to OUT_LANES decoded bytes
//
// Token byte: DECODE only. Literal byte: DECODE, RD, WR, EMIT, plus output stall.
// Length byte: DECODE, MLOOK and MCHK lookup, then RD and WR per copied byte
// (row-state read-modify-write and history read), plus EMIT per output word.
// Reset and new_stream run a row-state clearing pass over all CONTEXTS rows
// (4096) with the input held off.
// A full output register stalls the sequencer until out_ready.
module rolz_decompressor_core
  import rolz_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [6:0]        lits_r, lits_nxt;
  logic [SLOT_W-1:0] pslot_r, pslot_nxt;
  logic [31:0]       pos_r, pos_nxt;
  logic [7:0]        b_old_r, b_old_nxt;
  logic [7:0]        b_new_r, b_new_nxt;
  logic [1:0]        seen_r, seen_nxt;
  logic [1:0]        held_r, held_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              pend_r, pend_nxt;
  logic [KEY_W-1:0]  clr_r, clr_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       off_r, off_nxt;
  logic              match_r, match_nxt;
  logic              last_r, last_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              ovld_r, ovld_nxt;
  out_item_t         odata_r, odata_nxt;

  logic [KEY_W-1:0]   key;
  meta_t              meta_rd, meta_wd;
  logic               meta_we;
  logic [KEY_W-1:0]   meta_wa;
  logic [31:0]        ctx_rd;
  logic               ctx_we;
  logic [CTX_AW-1:0]  ctx_wa;
  logic [7:0]         hist_rd;
  logic               hist_we;
  logic [7:0]         wbyte;
  logic               final_b;
  logic [31:0]        gap;
  logic               slot_ok;

  assign key = ctx_key(b_old_r, b_new_r);

  rolz_ram #(.WIDTH(8), .DEPTH(HISTORY_SIZE)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (pos_r[HIST_AW-1:0]),
    .wdata (wbyte),
    .raddr (HIST_AW'(off_r + 32'(cnt_r))),
    .rdata (hist_rd)
  );

  rolz_ram #(.WIDTH(32), .DEPTH(CTX_DEPTH)) u_ctx (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (ctx_wa),
    .wdata (pos_r),
    .raddr ({key, pslot_r}),
    .rdata (ctx_rd)
  );

  rolz_ram #(.WIDTH($bits(meta_t)), .DEPTH(CONTEXTS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_wa),
    .wdata (meta_wd),
    .raddr (key),
    .rdata (meta_rd)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ovld_r;
  assign out_data  = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      phase_r <= PH_TOKEN;
      lits_r  <= '0;
      pslot_r <= '0;
      pos_r   <= '0;
      b_old_r <= '0;
      b_new_r <= '0;
      seen_r  <= '0;
      held_r  <= ERR_NONE;
      pend_r  <= 1'b0;
      clr_r   <= '0;
      fill_r  <= '0;
      acc_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      lits_r  <= lits_nxt;
      pslot_r <= pslot_nxt;
      pos_r   <= pos_nxt;
      b_old_r <= b_old_nxt;
      b_new_r <= b_new_nxt;
      seen_r  <= seen_nxt;
      held_r  <= held_nxt;
      pend_r  <= pend_nxt;
      clr_r   <= clr_nxt;
      fill_r  <= fill_nxt;
      acc_r   <= acc_nxt;
      ovld_r  <= ovld_nxt;
    end
    byte_r  <= byte_nxt;
    len_r   <= len_nxt;
    cnt_r   <= cnt_nxt;
    off_r   <= off_nxt;
    match_r <= match_nxt;
    last_r  <= last_nxt;
    odata_r <= odata_nxt;
  end

  assign gap     = pos_r - ctx_rd;
  assign slot_ok = meta_rd.wrapped || (pslot_r < meta_rd.next);
  assign wbyte   = match_r ? hist_rd : byte_r;
  assign final_b = !match_r || (cnt_r == len_r - LEN_W'(1));

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    lits_nxt  = lits_r;
    pslot_nxt = pslot_r;
    pos_nxt   = pos_r;
    b_old_nxt = b_old_r;
    b_new_nxt = b_new_r;
    seen_nxt  = seen_r;
    held_nxt  = held_r;
    byte_nxt  = byte_r;
    pend_nxt  = pend_r;
    clr_nxt   = clr_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    off_nxt   = off_r;
    match_nxt = match_r;
    last_nxt  = last_r;
    acc_nxt   = acc_r;
    fill_nxt  = fill_r;
    ovld_nxt  = ovld_r;
    odata_nxt = odata_r;
    meta_we   = 1'b0;
    meta_wa   = key;
    meta_wd   = '0;
    ctx_we    = 1'b0;
    ctx_wa    = {key, meta_rd.next};
    hist_we   = 1'b0;

    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_r;
        clr_nxt = clr_r + KEY_W'(1);
        if (clr_r == KEY_W'(CONTEXTS - 1)) begin
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? ST_DECODE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.in_byte;
          if (in_data.new_stream) begin
            phase_nxt = PH_TOKEN;
            lits_nxt  = '0;
            pslot_nxt = '0;
            pos_nxt   = '0;
            b_old_nxt = '0;
            b_new_nxt = '0;
            seen_nxt  = '0;
            held_nxt  = ERR_NONE;
            pend_nxt  = 1'b1;
            clr_nxt   = '0;
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        cnt_nxt   = '0;
        fill_nxt  = '0;
        acc_nxt   = '0;
        if (held_r != ERR_NONE) begin
          last_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          case (phase_r)
            PH_LITERAL: begin
              match_nxt = 1'b0;
              state_nxt = ST_RD;
              if (lits_r == '0) begin
                phase_nxt = PH_TOKEN;
              end else begin
                lits_nxt = lits_r - 7'd1;
              end
            end
            PH_LENGTH: begin
              phase_nxt = PH_TOKEN;
              match_nxt = 1'b1;
              len_nxt   = LEN_W'(byte_r) + LEN_W'(MIN_MATCH);
              last_nxt  = 1'b1;
              if ({1'b0, pslot_r} >= 8'(SLOTS_PER_CONTEXT)) begin
                held_nxt = ERR_INDEX;
                state_nxt = ST_EMIT;
              end else if (seen_r < 2'd2) begin
                held_nxt = ERR_EARLY;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_MLOOK;
              end
            end
            default: begin
              if (byte_r[7]) begin
                pslot_nxt = byte_r[6:0];
                phase_nxt = PH_LENGTH;
              end else begin
                lits_nxt  = byte_r[6:0];
                phase_nxt = PH_LITERAL;
              end
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MLOOK: begin
        state_nxt = ST_MCHK;
      end
      ST_MCHK: begin
        off_nxt = ctx_rd;
        if (!slot_ok || gap == 32'd0 || gap > 32'(HISTORY_SIZE)) begin
          held_nxt  = ERR_SLOT;
          last_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        hist_we = 1'b1;
        if (seen_r >= 2'd2) begin
          ctx_we  = 1'b1;
          meta_we = 1'b1;
          if (8'(meta_rd.next) + 8'd1 >= 8'(SLOTS_PER_CONTEXT)) begin
            meta_wd = '{wrapped: 1'b1, next: '0};
          end else begin
            meta_wd = '{wrapped: meta_rd.wrapped, next: meta_rd.next + SLOT_W'(1)};
          end
        end
        b_old_nxt = b_new_r;
        b_new_nxt = wbyte;
        pos_nxt   = pos_r + 32'd1;
        if (seen_r < 2'd2) begin
          seen_nxt = seen_r + 2'd1;
        end
        cnt_nxt  = cnt_r + LEN_W'(1);
        acc_nxt  = acc_r | ({56'b0, wbyte} << {fill_r, 3'b000});
        fill_nxt = fill_r + FILL_W'(1);
        if (fill_r + FILL_W'(1) == FILL_W'(OUT_LANES) || final_b) begin
          last_nxt  = final_b;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        if (!ovld_r || out_ready) begin
          ovld_nxt  = 1'b1;
          odata_nxt = '{out_bytes: acc_r, byte_count: 4'(fill_r),
                        last_of_run: last_r, error_code: held_r};
          acc_nxt   = '0;
          fill_nxt  = '0;
          state_nxt = last_r ? ST_IDLE : ST_RD;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != ERR_NONE
      |-> out_data.byte_count == 4'd0 && out_data.last_of_run)
    else $error("error transaction carries bytes");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code == ERR_NONE
      |-> out_data.byte_count != 4'd0 && out_data.byte_count <= 4'(OUT_LANES))
    else $error("bad byte count");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready)
    else $error("input taken during clearing pass");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted transaction not processed");
`endif

endmodule

@@ rtl/rolz_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rolz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/rolz_decompressor_core_tb.sv @@
// Self-checking testbench for rolz_decompressor_core: a scoreboard class predicts the
// decoded words of every accepted compressed byte; plain tasks drive the input channel.
// Depends on rolz_pkg and the RTL of the core.
module rolz_decompressor_core_tb;
  import rolz_pkg::*;

  class rolz_scoreboard;
    phase_t         phase;
    logic [6:0]     lits_left;
    logic [6:0]     match_slot;
    logic [31:0]    wr_pos;
    logic [7:0]     history [HISTORY_SIZE];
    logic [7:0]     older, newer;
    logic [31:0]    slot_pos [CTX_DEPTH];
    logic [6:0]     row_next [CONTEXTS];
    bit             row_full [CONTEXTS];
    logic [1:0]     held_code;
    int             seen;
    out_item_t      words [$];
    logic [63:0]    acc;
    int             fill;
    int             mismatches, results, faults, copies;

    function new();
      mismatches = 0; results = 0; faults = 0; copies = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      phase = PH_TOKEN; lits_left = 0; match_slot = 0; wr_pos = 0;
      older = 0; newer = 0; held_code = ERR_NONE; seen = 0;
      for (int i = 0; i < CONTEXTS; i++) begin
        row_next[i] = 0;
        row_full[i] = 0;
      end
    endfunction

    function logic [11:0] ctx();
      return {older, 4'b0000} ^ {4'b0000, newer};
    endfunction

    function int live_slots();
      logic [11:0] k;
      k = ctx();
      return row_full[k] ? SLOTS_PER_CONTEXT : int'(row_next[k]);
    endfunction

    function void push_word(logic [63:0] data, int cnt, logic [1:0] code);
      out_item_t r;
      r.out_bytes = data; r.byte_count = 4'(cnt); r.last_of_run = 0; r.error_code = code;
      words.push_back(r);
    endfunction

    function void flush();
      if (fill > 0) push_word(acc, fill, ERR_NONE);
      acc = 0; fill = 0;
    endfunction

    function void emit_byte(logic [7:0] b);
      logic [11:0] k;
      if (seen >= 2) begin
        k = ctx();
        slot_pos[{k, row_next[k]}] = wr_pos;
        if (row_next[k] == 7'(SLOTS_PER_CONTEXT - 1)) row_full[k] = 1;
        row_next[k] = row_next[k] + 7'd1;
      end
      history[wr_pos % HISTORY_SIZE] = b;
      older = newer; newer = b;
      wr_pos++;
      if (seen < 2) seen++;
      acc |= 64'(b) << (8 * fill);
      fill++;
      if (fill >= OUT_LANES) flush();
    endfunction

    function logic [1:0] copy_match(int len);
      logic [11:0] k;
      logic [31:0] src, gap;
      if (int'(match_slot) >= SLOTS_PER_CONTEXT) return ERR_INDEX;
      if (seen < 2) return ERR_EARLY;
      k = ctx();
      if (!row_full[k] && match_slot >= row_next[k]) return ERR_SLOT;
      src = slot_pos[{k, match_slot}];
      gap = wr_pos - src;
      if (gap == 0 || gap > HISTORY_SIZE) return ERR_SLOT;
      for (int x = 0; x < len; x++) emit_byte(history[(src + x) % HISTORY_SIZE]);
      copies++;
      return ERR_NONE;
    endfunction

    function void note(in_item_t it);
      int n0;
      logic [1:0] code;
      n0 = words.size();
      acc = 0; fill = 0;
      if (it.new_stream) clear_stream();
      if (held_code != ERR_NONE) begin
        push_word(0, 0, held_code);
        words[words.size()-1].last_of_run = 1;
        return;
      end
      case (phase)
        PH_LITERAL: begin
          emit_byte(it.in_byte);
          if (lits_left == 0) phase = PH_TOKEN;
          else lits_left--;
        end
        PH_LENGTH: begin
          phase = PH_TOKEN;
          code = copy_match(int'(it.in_byte) + MIN_MATCH);
          if (code != ERR_NONE) begin
            held_code = code;
            faults++;
            push_word(0, 0, code);
          end
        end
        default: begin
          if (it.in_byte[7]) begin
            match_slot = it.in_byte[6:0];
            phase = PH_LENGTH;
          end else begin
            lits_left = it.in_byte[6:0];
            phase = PH_LITERAL;
          end
        end
      endcase
      flush();
      if (words.size() > n0) words[words.size()-1].last_of_run = 1;
    endfunction

    function void check(out_item_t got);
      out_item_t exp;
      results++;
      if (words.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatches++;
        return;
      end
      exp = words.pop_front();
      if (got.out_bytes !== exp.out_bytes || got.byte_count !== exp.byte_count ||
          got.last_of_run !== exp.last_of_run || got.error_code !== exp.error_code) begin
        $display("%0t: mismatch expected bytes=%h cnt=%0d last=%0b err=%0d", $time,
                 exp.out_bytes, exp.byte_count, exp.last_of_run, exp.error_code);
        $display("%0t:          actual   bytes=%h cnt=%0d last=%0b err=%0d", $time,
                 got.out_bytes, got.byte_count, got.last_of_run, got.error_code);
        mismatches++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 5000000;
  localparam int RANDOM_ITEMS = 500;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  rolz_scoreboard sb;
  int in_idle, out_idle;
  int cycles, n_items;

  rolz_decompressor_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rolz_decompressor_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
    out_ready <= ($urandom_range(0, 99) >= out_idle);
  end

  task automatic send(input logic [7:0] b, input logic ns);
    in_item_t it;
    it.in_byte = b;
    it.new_stream = ns;
    while ($urandom_range(0, 99) < in_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note(it);
    n_items++;
  endtask

  // well-formed streams with random content, plus some noise
  task automatic send_random();
    logic [7:0] b;
    logic ns;
    int live;
    ns = (sb.held_code != ERR_NONE) ? ($urandom_range(0, 2) == 0)
                                    : ($urandom_range(0, 199) == 0);
    if ($urandom_range(0, 99) < 10) b = 8'($urandom);
    else if (ns || sb.phase == PH_TOKEN) begin
      live = sb.live_slots();
      if (ns) live = 0;
      if (live > 0 && $urandom_range(0, 1)) b = {1'b1, 7'($urandom_range(0, live - 1))};
      else if ($urandom_range(0, 19) == 0) b = 8'h7f;
      else b = 8'($urandom_range(0, 15));
    end else if (sb.phase == PH_LITERAL) begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) b = 8'hff;
    end else begin
      b = ($urandom_range(0, 15) == 0) ? 8'hff : 8'($urandom_range(0, 20));
    end
    send(b, ns);
  endtask

  initial begin
    sb = new();
    rst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
    n_items = 0;
    in_idle = 20; out_idle = 77;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    // match before two bytes, then held error
    send(8'h85, 1); send(8'h00, 0); send(8'h10, 0);
    // literals at both extremes, then unset slot
    send(8'h01, 1); send(8'hff, 0); send(8'h00, 0);
    send(8'hff, 0); send(8'h00, 0); send(8'h80, 0);
    // short repeating pattern, then longest overlapping match
    send(8'h03, 1); send(8'h61, 0); send(8'h62, 0); send(8'h61, 0); send(8'h62, 0);
    send(8'h80, 0); send(8'hff, 0);
    send(8'h00, 0); send(8'h80, 0); send(8'h80, 0); send(8'h00, 0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        in_idle = 77; out_idle = 20;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        in_idle = 0; out_idle = 0;
      end
      send_random();
    end
    in_valid <= 0;
    while (sb.words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Decoded %0d compressed bytes into %0d result words.", n_items, sb.results);
    $display("%0d matches copied, %0d stream errors flagged.", sb.copies, sb.faults);
    if (sb.mismatches == 0 && sb.words.size() == 0) begin
      $display("rolz_decompressor_core regression: pass");
    end else begin
      $display("rolz_decompressor_core regression: fail");
    end
    $finish;
  end

endmodule
